FILE: rtl/core/wlrs_pkg.sv
// Shared payload types and fixed constants for the windowed lane sampler.
package wlrs_pkg;

    typedef struct packed {
        logic signed [15:0] cv_sample;
        logic signed [15:0] step_level;
        logic signed [15:0] center_mod;
        logic signed [15:0] width_mod;
    } wlrs_in_t;

    typedef struct packed {
        logic signed [15:0] lane0_out;
        logic signed [15:0] lane1_out;
        logic signed [15:0] lane2_out;
        logic signed [15:0] lane3_out;
        logic        [3:0]  active_mask;
        logic               step_edge;
    } wlrs_out_t;

    typedef enum logic [2:0] {
        CFG_CENTER_OFFSET = 3'd0,
        CFG_CENTER_GAIN   = 3'd1,
        CFG_WIDTH_OFFSET  = 3'd2,
        CFG_WIDTH_GAIN    = 3'd3,
        CFG_LENGTH_LANE0  = 3'd4,
        CFG_LENGTH_LANE1  = 3'd5,
        CFG_LENGTH_LANE2  = 3'd6,
        CFG_LENGTH_LANE3  = 3'd7
    } wlrs_cfg_idx_t;

    localparam int OUT_LANES = 4;
    localparam int LEN_BITS  = 5;
    localparam int CFG_BITS  = 16;

    // Schmitt thresholds, volts times 2048
    localparam logic signed [15:0] TRIG_HIGH_LEVEL = 16'sd4096;
    localparam logic signed [15:0] TRIG_LOW_LEVEL  = 16'sd0;

    // Lane n sits at n * 2.5 V - 5 V
    localparam int LANE_STEP_V = 5120;
    localparam int LANE_BASE_V = -10240;

    localparam logic signed [15:0] SAT16_MAX = 16'sh7FFF;
    localparam logic signed [15:0] SAT16_MIN = 16'sh8000;

endpackage

FILE: rtl/core/windowed_lane_recirculating_sampler_unit.sv
// Top level of the windowed lane recirculating sampler.
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------
//  in       | in_valid / in_stall  | in_data  (wlrs_in_t)
//  out      | out_valid / out_stall| out_data (wlrs_out_t)
//  cfg      | cfg_wen              | cfg_index, cfg_data
//
//  One transfer per cycle while nothing stalls; a result passes the input
//  register, the product and buffer read registers, then the result register.
//  After reset the buffers are cleared with in_stall high. A lane length
//  write holds in_stall while each lane's wrap position is recomputed serially.
//  out_stall holds the pipeline; input is still taken while stages are empty.
module windowed_lane_recirculating_sampler_unit #(
    parameter int LANE_COUNT   = 4,
    parameter int BUFFER_DEPTH = 16,
    parameter int SAMPLE_BITS  = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  wlrs_pkg::wlrs_in_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output wlrs_pkg::wlrs_out_t                 out_data,
    input  logic                                cfg_wen,
    input  logic [2:0]                          cfg_index,
    input  logic [wlrs_pkg::CFG_BITS-1:0]       cfg_data
);
    import wlrs_pkg::*;

    localparam int AW   = $clog2(BUFFER_DEPTH);
    localparam int SMax = (1 << (SAMPLE_BITS - 1)) - 1;

    // configuration
    logic signed [14:0] center_offset_reg;
    logic signed [15:0] center_gain_reg;
    logic        [13:0] width_offset_reg;
    logic signed [15:0] width_gain_reg;
    logic [OUT_LANES-1:0][LEN_BITS-1:0] lane_len_reg;
    logic               fix_start;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_offset_reg <= '0;
            center_gain_reg   <= '0;
            width_offset_reg  <= '0;
            width_gain_reg    <= '0;
            for (int i = 0; i < OUT_LANES; i++)
                lane_len_reg[i] <= LEN_BITS'(1);
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                CFG_CENTER_OFFSET: center_offset_reg <= cfg_data[14:0];
                CFG_CENTER_GAIN:   center_gain_reg   <= cfg_data;
                CFG_WIDTH_OFFSET:  width_offset_reg  <= cfg_data[13:0];
                CFG_WIDTH_GAIN:    width_gain_reg    <= cfg_data;
                CFG_LENGTH_LANE0:  lane_len_reg[0]   <= cfg_data[LEN_BITS-1:0];
                CFG_LENGTH_LANE1:  lane_len_reg[1]   <= cfg_data[LEN_BITS-1:0];
                CFG_LENGTH_LANE2:  lane_len_reg[2]   <= cfg_data[LEN_BITS-1:0];
                CFG_LENGTH_LANE3:  lane_len_reg[3]   <= cfg_data[LEN_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign fix_start = cfg_wen && (cfg_index inside {[CFG_LENGTH_LANE0:CFG_LENGTH_LANE3]});

    // pipeline control
    logic s1_v_reg, s2_v_reg, out_v_reg;
    logic out_ready, s2_free, s2_move, s1_free, s1_move, accept;
    logic clearing, fix_busy;

    assign out_ready = !out_v_reg || !out_stall;
    assign s2_move   = s2_v_reg && out_ready;
    assign s2_free   = !s2_v_reg || out_ready;
    assign s1_move   = s1_v_reg && s2_free;
    assign s1_free   = !s1_v_reg || s2_free;
    assign in_stall  = clearing || fix_busy || !s1_free;
    assign accept    = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
                s1_v_reg <= accept;
            if (s2_free)
                s2_v_reg <= s1_move;
            if (out_ready)
                out_v_reg <= s2_move;
        end
    end

    // step trigger, evaluated at the input transfer
    logic trig_reg, trig_next, edge_now;

    always_comb
    begin
        trig_next = trig_reg;
        edge_now  = 1'b0;
        if (!trig_reg)
        begin
            if (in_data.step_level >= TRIG_HIGH_LEVEL)
            begin
                trig_next = 1'b1;
                edge_now  = 1'b1;
            end
        end
        else if (in_data.step_level <= TRIG_LOW_LEVEL)
            trig_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            trig_reg <= 1'b0;
        else if (accept)
            trig_reg <= trig_next;
    end

    // positions
    logic [LANE_COUNT-1:0][AW-1:0] pos;

    wlrs_pos_ctl #(
        .LANE_COUNT   (LANE_COUNT),
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_pos (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (accept && edge_now),
        .fix_start (fix_start),
        .lane_len  (lane_len_reg),
        .pos       (pos),
        .busy      (fix_busy)
    );

    // stage one and two payload
    wlrs_in_t                      s1_in_reg;
    logic                          s1_edge_reg;
    logic [LANE_COUNT-1:0][AW-1:0] s1_addr_reg;
    logic signed [15:0]            s2_cv_reg;
    logic                          s2_edge_reg;
    logic [LANE_COUNT-1:0][AW-1:0] s2_addr_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_in_reg   <= in_data;
            s1_edge_reg <= edge_now;
            s1_addr_reg <= pos;
        end
        if (s1_move)
        begin
            s2_cv_reg   <= s1_in_reg.cv_sample;
            s2_edge_reg <= s1_edge_reg;
            s2_addr_reg <= s1_addr_reg;
        end
    end

    logic [LANE_COUNT-1:0] active;

    wlrs_window #(
        .LANE_COUNT (LANE_COUNT)
    ) u_window (
        .clk           (clk),
        .load          (s1_move),
        .center_offset (center_offset_reg),
        .center_gain   (center_gain_reg),
        .width_offset  (width_offset_reg),
        .width_gain    (width_gain_reg),
        .center_mod    (s1_in_reg.center_mod),
        .width_mod     (s1_in_reg.width_mod),
        .active        (active)
    );

    // captured sample saturates to the stored width
    logic signed [24:0]     cv_ext;
    logic [SAMPLE_BITS-1:0] sample;

    always_comb
    begin
        cv_ext = 25'(s2_cv_reg);
        if (cv_ext > 25'(SMax))
            sample = SAMPLE_BITS'(SMax);
        else if (cv_ext < 25'(-SMax - 1))
            sample = SAMPLE_BITS'(-SMax - 1);
        else
            sample = SAMPLE_BITS'(cv_ext);
    end

    logic [LANE_COUNT-1:0]                  wr_en;
    logic [LANE_COUNT-1:0][SAMPLE_BITS-1:0] rdata;

    assign wr_en = (s2_move && s2_edge_reg) ? active : '0;

    wlrs_lane_store #(
        .LANE_COUNT   (LANE_COUNT),
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (s1_move),
        .raddr    (s1_addr_reg),
        .rdata    (rdata),
        .wr_en    (wr_en),
        .waddr    (s2_addr_reg),
        .wdata    (sample),
        .clearing (clearing)
    );

    // result assembly; lanes without an output field are dropped
    logic [OUT_LANES-1:0][15:0] lane_val;
    logic [OUT_LANES-1:0]       mask;
    wlrs_out_t                  out_reg, out_next;

    for (genvar l = 0; l < OUT_LANES; l++)
    begin : g_out
        if (l < LANE_COUNT)
        begin : g_used
            logic signed [24:0] rd_ext;
            assign rd_ext      = 25'($signed(rdata[l]));
            assign lane_val[l] = rd_ext[15:0];
            assign mask[l]     = active[l];
        end
        else
        begin : g_absent
            assign lane_val[l] = '0;
            assign mask[l]     = 1'b0;
        end
    end

    always_comb
    begin
        out_next.lane0_out   = lane_val[0];
        out_next.lane1_out   = lane_val[1];
        out_next.lane2_out   = lane_val[2];
        out_next.lane3_out   = lane_val[3];
        out_next.active_mask = mask;
        out_next.step_edge   = s2_edge_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s2_move)
            out_reg <= out_next;
    end

    assign out_valid = out_v_reg;
    assign out_data  = out_reg;

endmodule

FILE: rtl/core/wlrs_window.sv
// Window arithmetic: gain products, then centre and width with lane compares.
module wlrs_window #(
    parameter int LANE_COUNT = 4
) (
    input  logic                   clk,
    input  logic                   load,
    input  logic signed [14:0]     center_offset,
    input  logic signed [15:0]     center_gain,
    input  logic        [13:0]     width_offset,
    input  logic signed [15:0]     width_gain,
    input  logic signed [15:0]     center_mod,
    input  logic signed [15:0]     width_mod,
    output logic [LANE_COUNT-1:0]  active
);
    import wlrs_pkg::*;

    logic signed [31:0] prod_c_reg, prod_c_next;
    logic signed [31:0] prod_w_reg, prod_w_next;
    logic signed [17:0] q_c, q_w;
    logic signed [18:0] c_sum, w_sum;
    logic signed [15:0] center, width;

    assign prod_c_next = center_gain * center_mod;
    assign prod_w_next = width_gain * width_mod;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_c_reg <= prod_c_next;
            prod_w_reg <= prod_w_next;
        end
    end

    // arithmetic shift gives the floor of the Q14 product
    assign q_c   = $signed(prod_c_reg[31:14]);
    assign q_w   = $signed(prod_w_reg[31:14]);
    assign c_sum = 19'(center_offset) + 19'(q_c);
    assign w_sum = 19'($signed({1'b0, width_offset})) + 19'(q_w);

    always_comb
    begin
        if (c_sum > 19'(SAT16_MAX))
            center = SAT16_MAX;
        else if (c_sum < 19'(SAT16_MIN))
            center = SAT16_MIN;
        else
            center = c_sum[15:0];

        if (w_sum > 19'(SAT16_MAX))
            width = SAT16_MAX;
        else if (w_sum < 19'(SAT16_MIN))
            width = SAT16_MIN;
        else
            width = w_sum[15:0];
    end

    for (genvar l = 0; l < LANE_COUNT; l++)
    begin : g_lane
        localparam int LaneV = l * LANE_STEP_V + LANE_BASE_V;
        logic signed [17:0] lane_v;
        logic signed [17:0] diff;
        logic        [17:0] dist_abs;

        assign lane_v   = 18'(LaneV);
        assign diff     = 18'(center) - lane_v;
        assign dist_abs = diff[17] ? 18'(-diff) : 18'(diff);
        // negative width leaves every lane outside
        assign active[l] = !width[15] && (dist_abs < {2'b00, width});
    end

endmodule

FILE: rtl/core/wlrs_lane_store.sv
// Per-lane sample buffers with a clearing sweep after reset and write-first bypass.
module wlrs_lane_store #(
    parameter int LANE_COUNT   = 4,
    parameter int BUFFER_DEPTH = 16,
    parameter int SAMPLE_BITS  = 16,
    localparam int AW = $clog2(BUFFER_DEPTH)
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  rd_en,
    input  logic [LANE_COUNT-1:0][AW-1:0]         raddr,
    output logic [LANE_COUNT-1:0][SAMPLE_BITS-1:0] rdata,
    input  logic [LANE_COUNT-1:0]                 wr_en,
    input  logic [LANE_COUNT-1:0][AW-1:0]         waddr,
    input  logic [SAMPLE_BITS-1:0]                wdata,
    output logic                                  clearing
);
    import wlrs_pkg::*;

    logic          clr_busy_reg, clr_busy_next;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;

    always_comb
    begin
        clr_busy_next = clr_busy_reg;
        clr_cnt_next  = clr_cnt_reg;
        if (clr_busy_reg)
        begin
            if (clr_cnt_reg == AW'(BUFFER_DEPTH - 1))
                clr_busy_next = 1'b0;
            else
                clr_cnt_next = clr_cnt_reg + AW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else
        begin
            clr_busy_reg <= clr_busy_next;
            clr_cnt_reg  <= clr_cnt_next;
        end
    end

    assign clearing = clr_busy_reg;

    for (genvar l = 0; l < LANE_COUNT; l++)
    begin : g_lane
        logic [SAMPLE_BITS-1:0] mem [BUFFER_DEPTH];
        logic [SAMPLE_BITS-1:0] rd_reg;
        logic                   we;
        logic [AW-1:0]          wa;
        logic [SAMPLE_BITS-1:0] wd;

        assign we = clr_busy_reg || wr_en[l];
        assign wa = clr_busy_reg ? clr_cnt_reg : waddr[l];
        assign wd = clr_busy_reg ? '0 : wdata;

        always_ff @(posedge clk)
        begin
            if (we)
                mem[wa] <= wd;
        end

        // a write landing on the same edge is passed straight through
        always_ff @(posedge clk)
        begin
            if (rd_en)
                rd_reg <= (we && (wa == raddr[l])) ? wd : mem[raddr[l]];
        end

        assign rdata[l] = rd_reg;
    end

endmodule

FILE: rtl/core/wlrs_pos_ctl.sv
// Lane positions with precomputed wrap and a serial modulo after a length change.
module wlrs_pos_ctl #(
    parameter int LANE_COUNT   = 4,
    parameter int BUFFER_DEPTH = 16,
    localparam int AW = $clog2(BUFFER_DEPTH)
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        advance,
    input  logic                                        fix_start,
    input  logic [wlrs_pkg::OUT_LANES-1:0][wlrs_pkg::LEN_BITS-1:0] lane_len,
    output logic [LANE_COUNT-1:0][AW-1:0]               pos,
    output logic                                        busy
);
    import wlrs_pkg::*;

    localparam int LW = $clog2(BUFFER_DEPTH + 1);
    localparam int KW = $clog2(LW);
    localparam int CW = (LW > LEN_BITS) ? LW : LEN_BITS;

    logic          fix_busy_reg, fix_busy_next;
    logic [KW-1:0] k_reg, k_next;
    logic          last_step;

    assign last_step = fix_busy_reg && (k_reg == KW'(0));

    always_comb
    begin
        fix_busy_next = fix_busy_reg;
        k_next        = k_reg;
        if (fix_start)
        begin
            fix_busy_next = 1'b1;
            k_next        = KW'(LW - 1);
        end
        else if (fix_busy_reg)
        begin
            if (k_reg == KW'(0))
                fix_busy_next = 1'b0;
            else
                k_next = k_reg - KW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fix_busy_reg <= 1'b0;
            k_reg        <= '0;
        end
        else
        begin
            fix_busy_reg <= fix_busy_next;
            k_reg        <= k_next;
        end
    end

    assign busy = fix_busy_reg || fix_start;

    for (genvar l = 0; l < LANE_COUNT; l++)
    begin : g_lane
        localparam int Src = (l < OUT_LANES) ? l : OUT_LANES - 1;
        logic [CW-1:0]     raw;
        logic [LW-1:0]     len;
        logic [AW-1:0]     pos_reg, pos_next;
        logic [AW-1:0]     nxt_reg, nxt_next;
        logic [LW-1:0]     r_reg, r_next, r_step;
        logic [LW-1:0]     nxt_inc;
        logic [2*LW-1:0]   len_sh;

        // zero acts as one, oversize clamps to the buffer depth
        assign raw = CW'(lane_len[Src]);
        always_comb
        begin
            if (raw == CW'(0))
                len = LW'(1);
            else if (raw > CW'(BUFFER_DEPTH))
                len = LW'(BUFFER_DEPTH);
            else
                len = LW'(raw);
        end

        assign len_sh  = {{LW{1'b0}}, len} << k_reg;
        assign r_step  = ({{LW{1'b0}}, r_reg} >= len_sh) ? r_reg - LW'(len_sh) : r_reg;
        assign nxt_inc = LW'(nxt_reg) + LW'(1);

        always_comb
        begin
            pos_next = pos_reg;
            nxt_next = nxt_reg;
            r_next   = r_reg;
            if (advance)
            begin
                pos_next = nxt_reg;
                nxt_next = (nxt_inc == len) ? '0 : AW'(nxt_inc);
            end
            else if (last_step)
                nxt_next = AW'(r_step);
            if (fix_start)
                r_next = LW'(pos_reg) + LW'(1);
            else if (fix_busy_reg)
                r_next = r_step;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                pos_reg <= '0;
                nxt_reg <= '0;
            end
            else
            begin
                pos_reg <= pos_next;
                nxt_reg <= nxt_next;
            end
        end

        always_ff @(posedge clk)
        begin
            r_reg <= r_next;
        end

        assign pos[l] = pos_reg;
    end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for the windowed lane sampler: directed and random sample ticks.
module testbench;
    import wlrs_pkg::*;

    localparam int LANES         = 4;
    localparam int DEPTH         = 16;
    localparam int PHASES        = 9;
    localparam int PHASE_TICKS   = 180;
    localparam int QUIET_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 8;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_stall;
    wlrs_in_t            in_data   = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    wlrs_out_t           out_data;
    logic                cfg_wen   = 1'b0;
    logic [2:0]          cfg_index = '0;
    logic [CFG_BITS-1:0] cfg_data  = '0;

    // Own copy of the sampler state and registers
    logic signed [15:0] lane_mem [LANES][DEPTH];
    logic [3:0]         lane_pos [LANES];
    logic               trig_high;
    int                 center_ofs;
    int                 center_gn;
    int                 width_ofs;
    int                 width_gn;
    logic [4:0]         len_reg [LANES];

    wlrs_out_t readouts_due [$];
    bit        calm = 1'b0;
    int        ticks_sent;
    int        results_seen;
    int        mismatches;
    int        edges_seen;
    int        settings_used;
    int        quiet_cycles;

    windowed_lane_recirculating_sampler_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic longint clip16(longint v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    function automatic void apply_reg(logic [2:0] idx, logic [CFG_BITS-1:0] val);
        case (wlrs_cfg_idx_t'(idx))
            CFG_CENTER_OFFSET: center_ofs = int'($signed(val[14:0]));
            CFG_CENTER_GAIN:   center_gn  = int'($signed(val));
            CFG_WIDTH_OFFSET:  width_ofs  = int'(val[13:0]);
            CFG_WIDTH_GAIN:    width_gn   = int'($signed(val));
            CFG_LENGTH_LANE0:  len_reg[0] = val[4:0];
            CFG_LENGTH_LANE1:  len_reg[1] = val[4:0];
            CFG_LENGTH_LANE2:  len_reg[2] = val[4:0];
            default:           len_reg[3] = val[4:0];
        endcase
    endfunction

    // Work out the readout of one tick and advance the lane state
    function automatic wlrs_out_t next_readout(wlrs_in_t t);
        wlrs_out_t          r;
        longint             center;
        longint             width;
        longint             diff;
        logic               fire;
        logic               act;
        logic signed [15:0] val;
        int                 n;
        int                 lim;
        r    = '0;
        fire = 1'b0;
        if (!trig_high)
        begin
            if (t.step_level >= TRIG_HIGH_LEVEL)
            begin
                trig_high = 1'b1;
                fire      = 1'b1;
            end
        end
        else if (t.step_level <= TRIG_LOW_LEVEL)
            trig_high = 1'b0;
        // floor of the Q2.14 product is an arithmetic shift
        center = clip16(longint'(center_ofs)
                        + ((longint'(center_gn) * longint'(t.center_mod)) >>> 14));
        width  = clip16(longint'(width_ofs)
                        + ((longint'(width_gn) * longint'(t.width_mod)) >>> 14));
        for (n = 0; n < LANES; n++)
        begin
            diff = center - longint'(n * LANE_STEP_V + LANE_BASE_V);
            if (diff < 0)
                diff = -diff;
            act = diff < width;
            val = lane_mem[n][lane_pos[n]];
            case (n)
                0:       r.lane0_out = val;
                1:       r.lane1_out = val;
                2:       r.lane2_out = val;
                default: r.lane3_out = val;
            endcase
            r.active_mask[n] = act;
            if (fire)
            begin
                if (act)
                    lane_mem[n][lane_pos[n]] = t.cv_sample;
                // zero length acts as one, anything past the depth saturates
                lim = (len_reg[n] == 0) ? 1 : ((len_reg[n] > DEPTH) ? DEPTH : int'(len_reg[n]));
                lane_pos[n] = 4'((int'(lane_pos[n]) + 1) % lim);
            end
        end
        r.step_edge = fire;
        if (fire)
            edges_seen++;
        return r;
    endfunction

    always @(posedge clk)
    begin
        wlrs_out_t want;
        logic      bad;
        if (rst_n)
        begin
            if (cfg_wen)
                apply_reg(cfg_index, cfg_data);
            if (in_valid && !in_stall)
            begin
                readouts_due.push_back(next_readout(in_data));
                ticks_sent++;
            end
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (readouts_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result with nothing outstanding: lanes %0d %0d %0d %0d",
                                 $realtime, out_data.lane0_out, out_data.lane1_out,
                                 out_data.lane2_out, out_data.lane3_out);
                end
                else
                begin
                    want = readouts_due.pop_front();
                    bad  = out_data.lane0_out !== want.lane0_out
                        || out_data.lane1_out !== want.lane1_out
                        || out_data.lane2_out !== want.lane2_out
                        || out_data.lane3_out !== want.lane3_out
                        || out_data.active_mask !== want.active_mask
                        || out_data.step_edge !== want.step_edge;
                    if (bad)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("%0t: result %0d expected lanes %0d %0d %0d %0d mask %b edge %b",
                                     $realtime, results_seen, want.lane0_out, want.lane1_out,
                                     want.lane2_out, want.lane3_out, want.active_mask,
                                     want.step_edge);
                            $display("%0t: result %0d actual   lanes %0d %0d %0d %0d mask %b edge %b",
                                     $realtime, results_seen, out_data.lane0_out,
                                     out_data.lane1_out, out_data.lane2_out, out_data.lane3_out,
                                     out_data.active_mask, out_data.step_edge);
                        end
                    end
                end
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            out_stall <= !calm && ($urandom_range(0, 99) < 7);
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $realtime, QUIET_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    function automatic wlrs_in_t make_tick(int cv, int lvl, int cm, int wm);
        wlrs_in_t t;
        t.cv_sample  = cv[15:0];
        t.step_level = lvl[15:0];
        t.center_mod = cm[15:0];
        t.width_mod  = wm[15:0];
        return t;
    endfunction

    task automatic send_tick(input wlrs_in_t t);
        while (!calm && $urandom_range(0, 99) < 7)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= t;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Drop valid and wait until every readout is back and the block takes input again
    task automatic quiesce();
        in_valid <= 1'b0;
        @(posedge clk);
        while (readouts_due.size() != 0 || in_stall)
            @(posedge clk);
    endtask

    task automatic write_reg(input wlrs_cfg_idx_t idx, input int val);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_BITS-1:0];
        @(posedge clk);
    endtask

    task automatic set_window(input int co, input int cg, input int wo, input int wg);
        quiesce();
        write_reg(CFG_CENTER_OFFSET, co);
        write_reg(CFG_CENTER_GAIN, cg);
        write_reg(CFG_WIDTH_OFFSET, wo);
        write_reg(CFG_WIDTH_GAIN, wg);
        cfg_wen <= 1'b0;
        settings_used++;
    endtask

    task automatic set_lengths(input int l0, input int l1, input int l2, input int l3);
        quiesce();
        write_reg(CFG_LENGTH_LANE0, l0);
        write_reg(CFG_LENGTH_LANE1, l1);
        write_reg(CFG_LENGTH_LANE2, l2);
        write_reg(CFG_LENGTH_LANE3, l3);
        cfg_wen <= 1'b0;
    endtask

    // Window wide open so every lane captures on an edge
    task automatic test_trigger_edges();
        set_window(0, 0, 10445, 0);
        send_tick(make_tick(32767, 4095, 0, 0));
        send_tick(make_tick(-32768, 4096, 0, 0));
        send_tick(make_tick(1234, 32767, 0, 0));
        send_tick(make_tick(-1234, 1, 0, 0));
        send_tick(make_tick(77, 0, 0, 0));
        send_tick(make_tick(-77, 4096, 0, 0));
        send_tick(make_tick(500, -32768, 0, 0));
        send_tick(make_tick(32767, 32767, 0, 0));
        send_tick(make_tick(0, -1, 0, 0));
    endtask

    // Saturated centre and width, negative width, both gain signs
    task automatic test_window_extremes();
        set_window(10445, 16384, 10445, 16384);
        send_tick(make_tick(111, 4096, 32767, 32767));
        send_tick(make_tick(222, 0, -32768, -32768));
        send_tick(make_tick(333, 4096, -32768, -32768));
        set_window(-10445, -16384, 0, -16384);
        send_tick(make_tick(444, 0, 0, 0));
        send_tick(make_tick(555, 5000, -32768, -32767));
        send_tick(make_tick(666, 0, 32767, 1000));
    endtask

    // Shorten lanes while their positions sit past the new length
    task automatic test_length_changes();
        set_window(0, 0, 10445, 0);
        set_lengths(16, 16, 5, 0);
        send_tick(make_tick(100, 4096, 0, 0));
        send_tick(make_tick(0, 0, 0, 0));
        send_tick(make_tick(101, 4096, 0, 0));
        send_tick(make_tick(0, 0, 0, 0));
        send_tick(make_tick(102, 4096, 0, 0));
        set_lengths(2, 31, 2, 17);
        send_tick(make_tick(-200, 8000, 0, 0));
        send_tick(make_tick(0, -4096, 0, 0));
        send_tick(make_tick(-201, 8000, 0, 0));
        send_tick(make_tick(0, -4096, 0, 0));
    endtask

    function automatic int pick_reg(int lo, int hi, int field_lo, int field_hi);
        case ($urandom_range(0, 9))
            0:       return lo;
            1:       return hi;
            2:       return field_lo + int'($urandom_range(0, field_hi - field_lo));
            default: return lo + int'($urandom_range(0, hi - lo));
        endcase
    endfunction

    function automatic int pick_mod();
        if ($urandom_range(0, 1) != 0)
            return int'($urandom_range(0, 65535)) - 32768;
        return int'($urandom_range(0, 24000)) - 12000;
    endfunction

    // Mostly clean high and low gate levels so edges come often, some noise
    function automatic wlrs_in_t rand_tick();
        int lvl;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: lvl = int'($urandom_range(4096, 32767));
            4, 5, 6, 7: lvl = -int'($urandom_range(0, 32768));
            8:          lvl = int'($urandom_range(0, 65535)) - 32768;
            default:
                case ($urandom_range(0, 3))
                    0:       lvl = 4095;
                    1:       lvl = 4096;
                    2:       lvl = 0;
                    default: lvl = 1;
                endcase
        endcase
        return make_tick(int'($urandom_range(0, 65535)) - 32768, lvl, pick_mod(), pick_mod());
    endfunction

    task automatic test_random_phases();
        int p;
        for (p = 0; p < PHASES; p++)
        begin
            set_window(pick_reg(-10445, 10445, -16384, 16383),
                       pick_reg(-16384, 16384, -32768, 32767),
                       pick_reg(0, 10445, 0, 16383),
                       pick_reg(-16384, 16384, -32768, 32767));
            set_lengths(pick_reg(1, 16, 0, 31), pick_reg(1, 16, 0, 31),
                        pick_reg(1, 16, 0, 31), pick_reg(1, 16, 0, 31));
            // one phase runs flat out on both sides
            calm = (p == PHASES / 2);
            repeat (PHASE_TICKS)
                send_tick(rand_tick());
            calm = 1'b0;
        end
    endtask

    initial
    begin
        int a;
        int b;
        int leftover;
        for (a = 0; a < LANES; a++)
        begin
            for (b = 0; b < DEPTH; b++)
                lane_mem[a][b] = '0;
            lane_pos[a] = '0;
            len_reg[a]  = 5'd1;
        end
        trig_high  = 1'b0;
        center_ofs = 0;
        center_gn  = 0;
        width_ofs  = 0;
        width_gn   = 0;

        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;

        test_trigger_edges();
        test_window_extremes();
        test_length_changes();
        test_random_phases();

        quiesce();
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        leftover = readouts_due.size();
        if (leftover != 0)
            $display("%0d readouts never arrived", leftover);

        $display("%0d ticks sent with %0d step edges, %0d results checked, %0d mismatches",
                 ticks_sent, edges_seen, results_seen, mismatches);
        $display("%0d window settings, lane lengths from 0 to 31, random output stalls",
                 settings_used);
        if (mismatches == 0 && leftover == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/wlrs_pkg.sv
rtl/core/wlrs_window.sv
rtl/core/wlrs_lane_store.sv
rtl/core/wlrs_pos_ctl.sv
rtl/core/windowed_lane_recirculating_sampler_unit.sv
tb/testbench.sv
